// ----- src/bsd_pkg.sv -----
// ----------------------------------------------------------------------------
// bsd_pkg: shared types and constants of the base32 stream decoder
// Alphabets, status and register codes, queue entry type, symbol lookup.
// ----------------------------------------------------------------------------
package bsd_pkg;

   // Result kinds
   localparam logic KIND_DATA   = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   // End-of-string status codes
   typedef enum logic [1:0] {
      STATUS_OK          = 2'd0,
      STATUS_BAD_CHAR    = 2'd1,
      STATUS_BAD_PADDING = 2'd2,
      STATUS_NO_PADDING  = 2'd3
   } status_type;

   // Configuration register indexes
   localparam logic REG_ALPHABET  = 1'b0;
   localparam logic REG_FORGIVING = 1'b1;

   // Alphabet variant codes; the two lowest are padded variants
   localparam logic [1:0] VARIANT_STD  = 2'd0;
   localparam logic [1:0] VARIANT_HEX  = 2'd1;
   localparam logic [1:0] VARIANT_CROCK = 2'd2;
   localparam logic [1:0] VARIANT_ZB   = 2'd3;

   // Most '=' characters allowed in a padded tail
   localparam logic [3:0] MAX_PADS = 4'd7;
   localparam logic [3:0] PAD_SATURATE = 4'd8;

   // Special characters
   localparam logic [7:0] CHAR_PAD   = 8'h3D;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_SPACE = 8'h20;

   // Alphabets: symbol 0 sits in the top byte
   localparam logic [255:0] ALPHA_STD   = "ABCDEFGHIJKLMNOPQRSTUVWXYZ234567";
   localparam logic [255:0] ALPHA_HEX   = "0123456789ABCDEFGHIJKLMNOPQRSTUV";
   localparam logic [255:0] ALPHA_CROCK = "0123456789ABCDEFGHJKMNPQRSTVWXYZ";
   localparam logic [255:0] ALPHA_ZB    = "ybndrfg8ejkmcpqxot1uwisza345h769";
   localparam logic [3:0][255:0] ALPHABETS = {ALPHA_ZB, ALPHA_CROCK, ALPHA_HEX, ALPHA_STD};

   // One queued item: an optional data byte followed by an optional status
   typedef struct packed {
      logic       has_byte;
      logic [7:0] data_byte;
      logic       has_status;
      status_type status;
   } entry_type;

   // Reverse lookup: {hit, 5-bit symbol value}
   function automatic logic [5:0] symbol_lookup(logic [1:0] variant, logic [7:0] c);
      logic       hit;
      logic [4:0] val;
      hit = 1'b0;
      val = 5'd0;
      for (int k = 0; k < 32; k++) begin
         if (ALPHABETS[variant][8*(31-k) +: 8] == c) begin
            hit = 1'b1;
            val = 5'(k);
         end
      end
      return {hit, val};
   endfunction

   function automatic logic is_space(logic [7:0] c);
      return (c == CHAR_CR) || (c == CHAR_TAB) || (c == CHAR_LF) || (c == CHAR_SPACE);
   endfunction

endpackage

// ----- src/bsd_req_if.sv -----
// ----------------------------------------------------------------------------
// bsd_req_if: character input channel
// Valid/ready channel carrying one text character per transaction.
// ----------------------------------------------------------------------------
interface bsd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_byte;
   logic       has_char;
   logic       end_of_text;

   modport source (output valid, char_byte, has_char, end_of_text, input ready);
   modport sink   (input valid, char_byte, has_char, end_of_text, output ready);
endinterface

// ----- src/bsd_rsp_if.sv -----
// ----------------------------------------------------------------------------
// bsd_rsp_if: result output channel
// Valid/ready channel carrying decoded bytes and end-of-string status.
// ----------------------------------------------------------------------------
interface bsd_rsp_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] data_byte;
   logic [1:0] status;
   logic       last_result;

   modport source (output valid, kind, data_byte, status, last_result, input ready);
   modport sink   (input valid, kind, data_byte, status, last_result, output ready);
endinterface

// ----- src/bsd_csr_if.sv -----
// ----------------------------------------------------------------------------
// bsd_csr_if: configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface bsd_csr_if;
   logic       valid;
   logic       ready;
   logic       index;
   logic [1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ----- src/bsd_result_queue.sv -----
// ----------------------------------------------------------------------------
// bsd_result_queue: two-entry result queue
// Holds per-item results and serializes byte and status onto the output.
// ----------------------------------------------------------------------------
module bsd_result_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  bsd_pkg::entry_type entry,
   output logic               has_space,
   bsd_rsp_if.source          rsp_chan
);
   import bsd_pkg::*;

   entry_type  slots_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       byte_sent_ff, byte_sent_in;

   entry_type head;
   logic      emit_byte;
   logic      pop;
   logic      take;

   // Present the head entry: byte first, then status
   always_comb begin
      rsp_chan.valid = (count_ff != 2'd0);
      head           = slots_ff[rd_ptr_ff];
      emit_byte      = head.has_byte && !byte_sent_ff;
      take           = rsp_chan.valid && rsp_chan.ready;
      pop            = take && !(emit_byte && head.has_status);

      rsp_chan.kind        = emit_byte ? KIND_DATA : KIND_STATUS;
      rsp_chan.data_byte   = emit_byte ? head.data_byte : 8'd0;
      rsp_chan.status      = emit_byte ? STATUS_OK : head.status;
      rsp_chan.last_result = !emit_byte;
      has_space            = (count_ff != 2'd2);

      wr_ptr_in    = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in    = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in     = count_ff + {1'b0, push} - {1'b0, pop};
      byte_sent_in = byte_sent_ff;
      if (pop) begin
         byte_sent_in = 1'b0;
      end else if (take) begin
         byte_sent_in = 1'b1;
      end
   end

   // Advance pointers and occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff    <= 1'b0;
         rd_ptr_ff    <= 1'b0;
         count_ff     <= 2'd0;
         byte_sent_ff <= 1'b0;
      end else begin
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         count_ff     <= count_in;
         byte_sent_ff <= byte_sent_in;
      end
   end

   // Store pushed entries
   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= entry;
      end
   end

endmodule

// ----- src/base32_stream_decoder_core.sv -----
// ----------------------------------------------------------------------------
// base32_stream_decoder_core: streaming base32 decoder
// Decodes one character per transaction in one of four alphabets.
// ----------------------------------------------------------------------------
// One character is accepted every clock cycle while the two-entry result
// queue has room; the symbol lookup, carry shift and tail checks finish in
// the accept cycle and land in the queue. A character gives at most one data
// byte, and the end_of_text transaction adds a status result, so a transaction
// that yields both gives two results; the output sets the sustained rate, one
// result per cycle unless stalled. Configuration writes (index 0 alphabet
// variant, index 1 forgiving mode) are always accepted and apply from the next
// character on. Bytes of a string whose status is not ok must be discarded.
module base32_stream_decoder_core (
   input  logic      clock,
   input  logic      reset,
   bsd_req_if.sink   req_chan,
   bsd_rsp_if.source rsp_chan,
   bsd_csr_if.sink   csr_chan
);
   import bsd_pkg::*;

   logic [1:0]  variant_ff;
   logic        forgiving_ff;
   logic        in_tail_ff, in_tail_in;
   logic [11:0] carry_ff, carry_in;
   logic [2:0]  count_ff, count_in;
   logic [3:0]  pads_ff, pads_in;
   logic        bad_ff, bad_in;

   logic        queue_space;
   logic        accept;
   logic        push;
   entry_type   entry;
   logic [5:0]  lookup;
   logic [3:0]  count5;
   logic [2:0]  shift;
   logic [2:0]  pad_bits;
   logic        padded;

   assign req_chan.ready = queue_space;
   assign csr_chan.ready = 1'b1;
   assign accept         = req_chan.valid && req_chan.ready;
   assign padded         = !variant_ff[1];

   // Decode the character and build the result entry
   always_comb begin
      in_tail_in = in_tail_ff;
      carry_in   = carry_ff;
      count_in   = count_ff;
      pads_in    = pads_ff;
      bad_in     = bad_ff;
      lookup     = symbol_lookup(variant_ff, req_chan.char_byte);
      count5     = {1'b0, count_ff} + 4'd5;
      shift      = 3'(count5 - 4'd8);
      pad_bits   = 3'd0;
      entry      = '{has_byte: 1'b0, data_byte: 8'd0, has_status: 1'b0, status: STATUS_OK};

      if (req_chan.has_char) begin
         if (!in_tail_ff && lookup[5]) begin
            carry_in = {carry_ff[6:0], lookup[4:0]};
            if (count5 >= 4'd8) begin
               entry.has_byte  = 1'b1;
               entry.data_byte = 8'(carry_in >> shift);
               count_in        = shift;
            end else begin
               count_in = count5[2:0];
            end
         end else if (in_tail_ff || !is_space(req_chan.char_byte)) begin
            in_tail_in = 1'b1;
            if (req_chan.char_byte == CHAR_PAD) begin
               if (pads_ff < PAD_SATURATE) begin
                  pads_in = pads_ff + 4'd1;
               end
            end else if (!is_space(req_chan.char_byte)) begin
               bad_in = 1'b1;
            end
         end
      end

      // Close the string: compute status, then clear for the next string
      if (req_chan.end_of_text) begin
         pad_bits         = count_in + 3'(pads_in[2:0] * 3'd5);
         entry.has_status = 1'b1;
         if (in_tail_in) begin
            if (!padded || bad_in) begin
               entry.status = STATUS_BAD_CHAR;
            end else if (pads_in > MAX_PADS || pad_bits != 3'd0) begin
               entry.status = STATUS_BAD_PADDING;
            end
         end else if (count_in != 3'd0 && padded && !forgiving_ff) begin
            entry.status = STATUS_NO_PADDING;
         end
         in_tail_in = 1'b0;
         carry_in   = 12'd0;
         count_in   = 3'd0;
         pads_in    = 4'd0;
         bad_in     = 1'b0;
      end

      push = accept && (entry.has_byte || entry.has_status);
   end

   // Hold decoder state; advance on each accepted transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         in_tail_ff <= 1'b0;
         carry_ff   <= 12'd0;
         count_ff   <= 3'd0;
         pads_ff    <= 4'd0;
         bad_ff     <= 1'b0;
      end else if (accept) begin
         in_tail_ff <= in_tail_in;
         carry_ff   <= carry_in;
         count_ff   <= count_in;
         pads_ff    <= pads_in;
         bad_ff     <= bad_in;
      end
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         variant_ff   <= VARIANT_STD;
         forgiving_ff <= 1'b0;
      end else if (csr_chan.valid && csr_chan.ready) begin
         case (csr_chan.index)
            REG_ALPHABET:  variant_ff   <= csr_chan.data;
            REG_FORGIVING: forgiving_ff <= csr_chan.data[0];
            default: begin
            end
         endcase
      end
   end

   bsd_result_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .entry     (entry),
      .has_space (queue_space),
      .rsp_chan  (rsp_chan)
   );

endmodule

// ----- src/bsd_checker.sv -----
// ----------------------------------------------------------------------------
// bsd_checker: port-level checks of the base32 stream decoder
// Result framing and output channel behavior, bound to the top level.
// ----------------------------------------------------------------------------
module bsd_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_kind,
   input logic [7:0] rsp_data_byte,
   input logic [1:0] rsp_status,
   input logic       rsp_last_result
);
   import bsd_pkg::*;

   // Status transaction is the last one and carries no byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_STATUS |-> rsp_last_result && rsp_data_byte == 8'd0)
      else $error("status transaction malformed");

   // Data transaction carries ok status and is never last
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_DATA |-> !rsp_last_result && rsp_status == STATUS_OK)
      else $error("data transaction malformed");

   // Drop all results on reset
   assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // Hold a stalled result
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind)
         && $stable(rsp_data_byte) && $stable(rsp_status))
      else $error("stalled result changed");

endmodule

bind base32_stream_decoder_core bsd_checker u_bsd_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_kind        (rsp_chan.kind),
   .rsp_data_byte   (rsp_chan.data_byte),
   .rsp_status      (rsp_chan.status),
   .rsp_last_result (rsp_chan.last_result)
);

// ----- sim/tb_base32_stream_decoder_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_base32_stream_decoder_core: testbench of the base32 stream decoder
// Streams characters in all four alphabets, directed corner strings first and
// then random strings, while a local decoder predicts every data byte and
// end-of-string status; results are compared field by field in order.
// ----------------------------------------------------------------------------
module tb_base32_stream_decoder_core;
   import bsd_pkg::*;

   localparam int CYCLE_LIMIT  = 500000;
   localparam int DRAIN_CYCLES = 4;
   localparam int RANDOM_CHARS = 1800;

   typedef struct packed {
      logic       kind;
      logic [7:0] data_byte;
      status_type status;
      logic       last_result;
   } decoder_result_type;

   logic clock;
   logic reset;

   bsd_req_if req_if ();
   bsd_rsp_if rsp_if ();
   bsd_csr_if csr_if ();

   base32_stream_decoder_core u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if.sink),
      .rsp_chan (rsp_if.source),
      .csr_chan (csr_if.sink)
   );

   // Expected decoder output, oldest first
   decoder_result_type decoded_expected[$];

   // Local copy of the decoder registers and string state
   logic [1:0]  cfg_variant   = VARIANT_STD;
   logic        cfg_forgiving = 1'b0;
   logic        dec_in_tail   = 1'b0;
   logic [11:0] dec_carry     = '0;
   logic [2:0]  dec_bits      = '0;
   logic [3:0]  dec_pads      = '0;
   logic        dec_tail_bad  = 1'b0;

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int fail_count     = 0;
   int chars_sent     = 0;
   int strings_sent   = 0;
   int results_seen   = 0;
   int cycle_count    = 0;

   // Clock: 20 ns period
   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // ------------------------------------------------------------------
   // Decoder prediction
   // ------------------------------------------------------------------
   function automatic logic [7:0] symbol_char(logic [1:0] variant, int k);
      return ALPHABETS[variant][8*(31-k) +: 8];
   endfunction

   function automatic int symbol_index(logic [1:0] variant, logic [7:0] c);
      for (int k = 0; k < 32; k++) begin
         if (symbol_char(variant, k) == c) return k;
      end
      return -1;
   endfunction

   function automatic logic is_blank(logic [7:0] c);
      return c == CHAR_CR || c == CHAR_TAB || c == CHAR_LF || c == CHAR_SPACE;
   endfunction

   function automatic void absorb_tail_char(logic [7:0] c);
      if (c == CHAR_PAD) begin
         if (dec_pads < PAD_SATURATE) dec_pads = dec_pads + 4'd1;
      end else if (!is_blank(c)) begin
         dec_tail_bad = 1'b1;
      end
   endfunction

   function automatic void predict_decode(logic [7:0] c, logic has_char, logic eot);
      int         idx;
      logic [3:0] held;
      logic [7:0] out_byte;
      status_type st;
      if (has_char) begin
         if (!dec_in_tail) begin
            idx = symbol_index(cfg_variant, c);
            if (idx >= 0) begin
               // shift the symbol in, emit a byte once 8 bits are held
               dec_carry = {dec_carry[6:0], idx[4:0]};
               held = {1'b0, dec_bits} + 4'd5;
               if (held >= 4'd8) begin
                  out_byte = 8'(dec_carry >> (held - 4'd8));
                  held = held - 4'd8;
                  decoded_expected.push_back('{KIND_DATA, out_byte, STATUS_OK, 1'b0});
               end
               dec_bits = held[2:0];
            end else if (!is_blank(c)) begin
               dec_in_tail = 1'b1;
               absorb_tail_char(c);
            end
         end else begin
            absorb_tail_char(c);
         end
      end
      if (eot) begin
         st = STATUS_OK;
         if (dec_in_tail) begin
            if (cfg_variant >= VARIANT_CROCK || dec_tail_bad)
               st = STATUS_BAD_CHAR;
            else if (dec_pads > MAX_PADS)
               st = STATUS_BAD_PADDING;
            else if (((int'(dec_bits) + 5 * int'(dec_pads)) % 8) != 0)
               st = STATUS_BAD_PADDING;
         end else if (dec_bits != 0 && cfg_variant < VARIANT_CROCK && !cfg_forgiving) begin
            st = STATUS_NO_PADDING;
         end
         decoded_expected.push_back('{KIND_STATUS, 8'h00, st, 1'b1});
         dec_in_tail  = 1'b0;
         dec_carry    = '0;
         dec_bits     = '0;
         dec_pads     = '0;
         dec_tail_bad = 1'b0;
         strings_sent++;
      end
   endfunction

   // ------------------------------------------------------------------
   // Drivers
   // ------------------------------------------------------------------
   // Send one character transaction, idling first at the current rate
   task automatic send_char(logic [7:0] c, logic has_char, logic eot);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.char_byte   <= c;
      req_if.has_char    <= has_char;
      req_if.end_of_text <= eot;
      do @(posedge clock); while (!req_if.ready);
      predict_decode(c, has_char, eot);
      if (has_char || eot) chars_sent++;
   endtask

   task automatic send_text(string s, logic eot);
      for (int k = 0; k < s.len(); k++)
         send_char(s[k], 1'b1, eot && (k == s.len() - 1));
   endtask

   // Hold the input until every expected result has come out
   task automatic wait_for_output_drain();
      req_if.valid <= 1'b0;
      while (decoded_expected.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic index, logic [1:0] value);
      wait_for_output_drain();
      csr_if.valid <= 1'b1;
      csr_if.index <= index;
      csr_if.data  <= value;
      do @(posedge clock); while (!csr_if.ready);
      if (index == REG_ALPHABET) cfg_variant = value;
      else cfg_forgiving = value[0];
      csr_if.valid <= 1'b0;
   endtask

   // ------------------------------------------------------------------
   // Output checker and receiver stalls
   // ------------------------------------------------------------------
   always @(posedge clock) begin : check_output
      decoder_result_type exp_res;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            results_seen++;
            if (decoded_expected.size() == 0) begin
               $error("unexpected result: kind %0d data_byte %h status %0d",
                      rsp_if.kind, rsp_if.data_byte, rsp_if.status);
               fail_count++;
            end else begin
               exp_res = decoded_expected.pop_front();
               if (rsp_if.kind !== exp_res.kind) begin
                  $error("kind: expected %0d, actual %0d", exp_res.kind, rsp_if.kind);
                  fail_count++;
               end
               if (rsp_if.data_byte !== exp_res.data_byte) begin
                  $error("data_byte: expected %h, actual %h",
                         exp_res.data_byte, rsp_if.data_byte);
                  fail_count++;
               end
               if (rsp_if.status !== exp_res.status) begin
                  $error("status: expected %0d, actual %0d", exp_res.status, rsp_if.status);
                  fail_count++;
               end
               if (rsp_if.last_result !== exp_res.last_result) begin
                  $error("last_result: expected %0d, actual %0d",
                         exp_res.last_result, rsp_if.last_result);
                  fail_count++;
               end
            end
         end
         rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Stop a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------
   // Empty string, ignored transaction, NUL character
   task automatic test_empty_and_ignored();
      send_char(8'h00, 1'b0, 1'b1);
      send_char(8'hFF, 1'b0, 1'b0);
      send_char(8'h00, 1'b1, 1'b1);
   endtask

   // Padded alphabets: missing padding, full padded string, forgiving mode
   task automatic test_padded_alphabets();
      send_text("A", 1'b1);
      send_text("MZ", 1'b0);
      // pause mid-string until the output has drained
      wait_for_output_drain();
      send_text("XW6===", 1'b1);
      write_reg(REG_ALPHABET, VARIANT_HEX);
      send_text("VV", 1'b1);
      write_reg(REG_FORGIVING, 2'd1);
      send_text("V0", 1'b1);
   endtask

   // Foreign character after padding wins over the padding check
   task automatic test_tail_errors();
      write_reg(REG_ALPHABET, VARIANT_STD);
      send_text("AA=*", 1'b1);
   endtask

   // Unpadded alphabets: leftover bits dropped, foreign byte rejected
   task automatic test_unpadded_alphabets();
      write_reg(REG_ALPHABET, VARIANT_CROCK);
      send_text("ZZ", 1'b1);
      send_char(8'hFF, 1'b1, 1'b1);
      write_reg(REG_ALPHABET, VARIANT_ZB);
      send_text("99", 1'b1);
   endtask

   function automatic logic [7:0] random_blank();
      case ($urandom_range(3))
         0: return CHAR_CR;
         1: return CHAR_TAB;
         2: return CHAR_LF;
         default: return CHAR_SPACE;
      endcase
   endfunction

   // One random string: mostly well formed, the rest noise
   task automatic send_random_string();
      logic [7:0] text[$];
      int         n;
      int         pads;
      int         pick;
      logic       split_eot;
      if ($urandom_range(99) < 30)
         wait_for_output_drain();
      if ($urandom_range(99) < 70) begin
         n = $urandom_range(16);
         if (n % 8 == 1 || n % 8 == 3 || n % 8 == 6) n++;
         for (int k = 0; k < n; k++)
            text.push_back(symbol_char(cfg_variant, $urandom_range(31)));
         pads = (cfg_variant < VARIANT_CROCK) ? (8 - n % 8) % 8 : 0;
         // drop the padding now and then
         if ($urandom_range(9) == 0) pads = 0;
         repeat (pads) text.push_back(CHAR_PAD);
      end else begin
         n = $urandom_range(1, 12);
         for (int k = 0; k < n; k++) begin
            pick = $urandom_range(99);
            if (pick < 40) text.push_back(symbol_char(cfg_variant, $urandom_range(31)));
            else if (pick < 55) text.push_back(CHAR_PAD);
            else if (pick < 65) text.push_back(random_blank());
            else text.push_back(8'($urandom_range(255)));
         end
         if ($urandom_range(3) == 0) repeat ($urandom_range(10)) text.push_back(CHAR_PAD);
      end
      split_eot = (text.size() == 0) || ($urandom_range(3) == 0);
      foreach (text[k]) begin
         if ($urandom_range(11) == 0) send_char(random_blank(), 1'b1, 1'b0);
         if ($urandom_range(24) == 0) send_char(8'($urandom_range(255)), 1'b0, 1'b0);
         send_char(text[k], 1'b1, !split_eot && (k == text.size() - 1));
      end
      if (split_eot) send_char(8'($urandom_range(255)), 1'b0, 1'b1);
   endtask

   // Random strings over every alphabet and forgiving setting
   task automatic test_random_traffic(int phase, int chars_per_setting);
      int target;
      for (int setting = 0; setting < 4; setting++) begin
         write_reg(REG_ALPHABET, 2'(setting));
         write_reg(REG_FORGIVING, 2'((phase + setting) % 2));
         target = chars_sent + chars_per_setting;
         while (chars_sent < target) send_random_string();
      end
   endtask

   // ------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------
   initial begin
      int idle_send[4];
      int idle_recv[4];
      idle_send = '{0, 81, 0, 9};
      idle_recv = '{0, 0, 81, 9};
      reset              <= 1'b1;
      req_if.valid       <= 1'b0;
      req_if.char_byte   <= 8'h00;
      req_if.has_char    <= 1'b0;
      req_if.end_of_text <= 1'b0;
      csr_if.valid       <= 1'b0;
      csr_if.index       <= REG_ALPHABET;
      csr_if.data        <= VARIANT_STD;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_and_ignored();
      test_padded_alphabets();
      test_tail_errors();
      test_unpadded_alphabets();

      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct  = idle_send[phase];
         recv_stall_pct = idle_recv[phase];
         test_random_traffic(phase, RANDOM_CHARS / 16);
      end

      send_idle_pct  = 0;
      recv_stall_pct = 0;
      wait_for_output_drain();
      repeat (2 * DRAIN_CYCLES) @(posedge clock);

      $display("Decoded %0d strings from %0d character transactions into %0d results,",
               strings_sent, chars_sent, results_seen);
      $display("across four alphabets, both padding modes and four idle patterns.");
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
